### design/rmms_pkg.sv
`timescale 1ns / 1ps
// shared widths and constants for the running statistics block
package rmms_pkg;

	localparam int DIV_W    = 64;
	localparam int SUM_W    = 64;
	localparam int STD_W    = 32;
	localparam int MEAN_W   = 40;
	localparam int VAR_FRAC = 16;

endpackage

### design/running_mean_min_max_stddev.sv
`timescale 1ns / 1ps
// running count, mean, min, max and standard deviation over signed samples
// steps: an add runs the 64-step divider for the mean, the bit-serial multiplier for the
// squared deviation, the divider again for the variance and the 32-step root; an add at
// full count runs only the divider and the root, and a clear goes straight to the result
// throughput: one item at a time, sample_stall stays high until the result is registered,
// and a stalled result holds the block in its last step
// reset: arst_n clears all statistics, flags and result_valid
module running_mean_min_max_stddev #(
	parameter int SAMPLE_BITS = 24,
	parameter int COUNT_BITS  = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic                        mode,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [COUNT_BITS-1:0]       sample_count,
	output logic signed [rmms_pkg::MEAN_W-1:0] mean_value,
	output logic signed [SAMPLE_BITS-1:0] min_value,
	output logic signed [SAMPLE_BITS-1:0] max_value,
	output logic [rmms_pkg::STD_W-1:0]  std_dev,
	output logic                        sum_saturated,
	output logic                        count_full
);
	import rmms_pkg::*;

	localparam int XW   = SAMPLE_BITS + FRAC_BITS;
	localparam int MAW  = XW + 1;
	localparam int PW   = 2 * MAW;
	localparam int SH_L = (FRAC_BITS <= VAR_FRAC) ? VAR_FRAC - FRAC_BITS : 0;
	localparam int SH_R = (FRAC_BITS > VAR_FRAC) ? FRAC_BITS - VAR_FRAC : 0;

	typedef enum logic [3:0] {
		S_IDLE, S_D1, S_DIV1, S_D2, S_MUL, S_STD, S_DIV2, S_SQRT, S_EMIT
	} state_t;

	state_t state_q;

	logic [COUNT_BITS-1:0]         count_q;
	logic signed [XW-1:0]          mean_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic [SUM_W-1:0]              sum_q;
	logic                          sat_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [MAW-1:0]                d1_q;
	logic                          d1_neg_q;
	logic [MAW-1:0]                d2_q;
	logic [STD_W-1:0]              std_r_q;
	logic [SUM_W-1:0]              sqrt_in_q;
	logic                          div_start_q;
	logic                          div_sel_q;
	logic                          mul_start_q;
	logic                          sqrt_start_q;
	logic                          result_valid_q;

	logic [COUNT_BITS-1:0]         sample_count_q;
	logic signed [MEAN_W-1:0]      mean_value_q;
	logic signed [SAMPLE_BITS-1:0] min_value_q;
	logic signed [SAMPLE_BITS-1:0] max_value_q;
	logic [STD_W-1:0]              std_dev_q;
	logic                          sum_saturated_q;
	logic                          count_full_q;

	logic [DIV_W-1:0] div_dvd_c;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;
	logic             mul_done;
	logic [PW-1:0]    mul_prod;
	logic             sqrt_done;
	logic [STD_W-1:0] sqrt_root;

	logic signed [XW-1:0] x_c;
	logic [XW:0]          d_c;
	logic [MAW-1:0]       d_mag_c;
	logic [XW+1:0]        q_ext_c;
	logic [XW+1:0]        q_sgn_c;
	logic [XW+1:0]        mean_nx_c;
	logic                 over_c;
	logic [SUM_W-1:0]     term_c;
	logic [SUM_W:0]       sum_nx_c;
	logic                 v_over_c;
	logic [SUM_W-1:0]     v_scaled_c;
	logic                 accept_c;
	logic                 out_free_c;

	assign x_c     = {sample_q, {FRAC_BITS{1'b0}}};
	assign d_c     = {x_c[XW-1], x_c} - {mean_q[XW-1], mean_q};
	assign d_mag_c = d_c[XW] ? (~d_c + MAW'(1)) : d_c;

	assign q_ext_c   = {1'b0, div_quot[XW:0]};
	assign q_sgn_c   = d1_neg_q ? (~q_ext_c + (XW + 2)'(1)) : q_ext_c;
	assign mean_nx_c = {{2{mean_q[XW-1]}}, mean_q} + q_sgn_c;

	assign over_c   = (mul_prod >> (SUM_W + FRAC_BITS)) != '0;
	assign term_c   = SUM_W'(mul_prod >> FRAC_BITS);
	assign sum_nx_c = {1'b0, sum_q} + {1'b0, term_c};

	assign v_over_c   = (div_quot >> (DIV_W - SH_L)) != '0;
	assign v_scaled_c = (div_quot << SH_L) >> SH_R;

	assign div_dvd_c  = div_sel_q ? sum_q : DIV_W'(d1_q);
	assign accept_c   = sample_valid && (state_q == S_IDLE);
	assign out_free_c = !result_valid_q || !result_stall;

	rmms_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(div_dvd_c),
		.divisor (count_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	rmms_mul #(
		.W(MAW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (d1_q),
		.b      (d2_q),
		.done   (mul_done),
		.product(mul_prod)
	);

	rmms_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start_q),
		.radicand(sqrt_in_q),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			mean_q          <= '0;
			min_q           <= '0;
			max_q           <= '0;
			sum_q           <= '0;
			sat_q           <= 1'b0;
			sample_q        <= '0;
			d1_q            <= '0;
			d1_neg_q        <= 1'b0;
			d2_q            <= '0;
			std_r_q         <= '0;
			sqrt_in_q       <= '0;
			div_start_q     <= 1'b0;
			div_sel_q       <= 1'b0;
			mul_start_q     <= 1'b0;
			sqrt_start_q    <= 1'b0;
			result_valid_q  <= 1'b0;
			sample_count_q  <= '0;
			mean_value_q    <= '0;
			min_value_q     <= '0;
			max_value_q     <= '0;
			std_dev_q       <= '0;
			sum_saturated_q <= 1'b0;
			count_full_q    <= 1'b0;
		end else begin
			div_start_q  <= 1'b0;
			mul_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
			if (state_q == S_EMIT && out_free_c) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept_c) begin
						sample_q <= sample;
						if (mode) begin
							count_q <= '0;
							mean_q  <= '0;
							min_q   <= '0;
							max_q   <= '0;
							sum_q   <= '0;
							sat_q   <= 1'b0;
							state_q <= S_STD;
						end else if (&count_q) begin
							state_q <= S_STD;
						end else begin
							state_q <= S_D1;
						end
					end
				end
				S_D1: begin
					count_q     <= count_q + COUNT_BITS'(1);
					d1_q        <= d_mag_c;
					d1_neg_q    <= d_c[XW];
					div_sel_q   <= 1'b0;
					div_start_q <= 1'b1;
					state_q     <= S_DIV1;
				end
				S_DIV1: begin
					if (div_done) begin
						mean_q <= mean_nx_c[XW-1:0];
						if (count_q == COUNT_BITS'(1) || sample_q < min_q) begin
							min_q <= sample_q;
						end
						if (count_q == COUNT_BITS'(1) || sample_q > max_q) begin
							max_q <= sample_q;
						end
						state_q <= S_D2;
					end
				end
				S_D2: begin
					d2_q        <= d_mag_c;
					mul_start_q <= 1'b1;
					state_q     <= S_MUL;
				end
				S_MUL: begin
					if (mul_done) begin
						if (over_c || sum_nx_c[SUM_W]) begin
							sum_q <= '1;
							sat_q <= 1'b1;
						end else begin
							sum_q <= sum_nx_c[SUM_W-1:0];
						end
						state_q <= S_STD;
					end
				end
				S_STD: begin
					if (count_q == '0) begin
						std_r_q <= '0;
						state_q <= S_EMIT;
					end else begin
						div_sel_q   <= 1'b1;
						div_start_q <= 1'b1;
						state_q     <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						if (v_over_c) begin
							std_r_q <= '1;
							state_q <= S_EMIT;
						end else begin
							sqrt_in_q    <= v_scaled_c;
							sqrt_start_q <= 1'b1;
							state_q      <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						std_r_q <= sqrt_root;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free_c) begin
						sample_count_q  <= count_q;
						mean_value_q    <= MEAN_W'(mean_q);
						min_value_q     <= min_q;
						max_value_q     <= max_q;
						std_dev_q       <= std_r_q;
						sum_saturated_q <= sat_q;
						count_full_q    <= &count_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign sample_stall  = (state_q != S_IDLE);
	assign result_valid  = result_valid_q;
	assign sample_count  = sample_count_q;
	assign mean_value    = mean_value_q;
	assign min_value     = min_value_q;
	assign max_value     = max_value_q;
	assign std_dev       = std_dev_q;
	assign sum_saturated = sum_saturated_q;
	assign count_full    = count_full_q;

endmodule

### design/rmms_div.sv
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
module rmms_div #(
	parameter int COUNT_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rmms_pkg::DIV_W-1:0] dividend,
	input  logic [COUNT_BITS-1:0]      divisor,
	output logic                       done,
	output logic [rmms_pkg::DIV_W-1:0] quotient
);
	import rmms_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0]      dvd_q;
	logic [COUNT_BITS-1:0] dsr_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [COUNT_BITS:0] rem_sh_c;
	logic                ge_c;
	logic [COUNT_BITS:0] rem_nx_c;

	assign rem_sh_c = {rem_q, dvd_q[DIV_W-1]};
	assign ge_c     = rem_sh_c >= {1'b0, dsr_q};
	assign rem_nx_c = ge_c ? (rem_sh_c - {1'b0, dsr_q}) : rem_sh_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge_c};
			rem_q <= rem_nx_c[COUNT_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

### design/rmms_mul.sv
`timescale 1ns / 1ps
// iterative shift-add multiplier, one multiplier bit per cycle
module rmms_mul #(
	parameter int W = 41
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] product
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  mcand_q;
	logic [W-1:0]  hi_q;
	logic [W-1:0]  lo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0] sum_c;

	assign sum_c = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= a;
			hi_q    <= '0;
			lo_q    <= b;
		end else if (busy_q) begin
			hi_q <= sum_c[W:1];
			lo_q <= {sum_c[0], lo_q[W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

### design/rmms_sqrt.sv
`timescale 1ns / 1ps
// iterative floor square root, one root bit per cycle
module rmms_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rmms_pkg::SUM_W-1:0] radicand,
	output logic                       done,
	output logic [rmms_pkg::STD_W-1:0] root
);
	import rmms_pkg::*;

	localparam int CW = $clog2(STD_W + 1);
	localparam int RW = STD_W + 2;

	logic [SUM_W-1:0] rad_q;
	logic [RW-1:0]    rem_q;
	logic [STD_W-1:0] root_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RW+1:0] rem_sh_c;
	logic [RW+1:0] trial_c;
	logic          ge_c;
	logic [RW+1:0] rem_nx_c;

	assign rem_sh_c = {rem_q, rad_q[SUM_W-1:SUM_W-2]};
	assign trial_c  = {2'b00, root_q, 2'b01};
	assign ge_c     = rem_sh_c >= trial_c;
	assign rem_nx_c = ge_c ? (rem_sh_c - trial_c) : rem_sh_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= rem_nx_c[RW-1:0];
			root_q <= {root_q[STD_W-2:0], ge_c};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### design/rmms_checker.sv
`timescale 1ns / 1ps
// port-level checks for the running statistics block, with its bind
module rmms_checker #(
	parameter int SAMPLE_BITS = 24,
	parameter int COUNT_BITS  = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_stall,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [COUNT_BITS-1:0]         sample_count,
	input logic signed [rmms_pkg::MEAN_W-1:0] mean_value,
	input logic signed [SAMPLE_BITS-1:0] min_value,
	input logic signed [SAMPLE_BITS-1:0] max_value,
	input logic [rmms_pkg::STD_W-1:0]    std_dev,
	input logic                          sum_saturated,
	input logic                          count_full
);
	import rmms_pkg::*;

	// empty statistics report all zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && sample_count == '0 |->
			mean_value == '0 && min_value == '0 && max_value == '0 && std_dev == '0)
		else $error("empty result not zero");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> count_full == (&sample_count))
		else $error("count_full disagrees with sample_count");

	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> min_value <= max_value)
		else $error("min above max");

	// an accepted item keeps the input side busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("item accepted while previous one in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(sample_count) && $stable(mean_value) && $stable(std_dev))
		else $error("stalled item changed");

endmodule

bind running_mean_min_max_stddev rmms_checker #(
	.SAMPLE_BITS(SAMPLE_BITS),
	.COUNT_BITS (COUNT_BITS)
) u_rmms_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the running statistics block: predicts and compares every result
module tb_top;

	localparam int SAMPLE_W = 24;
	localparam int CNT_W    = 16;
	localparam int FRAC_W   = 16;
	localparam int LIMIT    = 3_000_000;
	localparam int ITEMS    = 1800;
	localparam int LONG_RUN = 300;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct {
		logic [CNT_W-1:0]                  cnt;
		logic signed [rmms_pkg::MEAN_W-1:0] mean;
		logic signed [SAMPLE_W-1:0]        lo;
		logic signed [SAMPLE_W-1:0]        hi;
		logic [rmms_pkg::STD_W-1:0]        sd;
		logic                              sat;
		logic                              full;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic mode = OP_ADD;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [CNT_W-1:0] sample_count;
	logic signed [rmms_pkg::MEAN_W-1:0] mean_value;
	logic signed [SAMPLE_W-1:0] min_value;
	logic signed [SAMPLE_W-1:0] max_value;
	logic [rmms_pkg::STD_W-1:0] std_dev;
	logic sum_saturated;
	logic count_full;

	// predicted statistics
	logic [CNT_W-1:0]           n_acc = '0;
	longint                     mean_acc = 0;
	logic signed [SAMPLE_W-1:0] min_acc = '0;
	logic signed [SAMPLE_W-1:0] max_acc = '0;
	logic [63:0]                sq_acc = '0;
	logic                       sat_acc = 1'b0;

	stats_t stats_due[$];
	int     mismatches = 0;
	int     items_sent = 0;
	int     cycles = 0;
	int     hold_left = 0;
	bit     quiet = 1'b0;

	running_mean_min_max_stddev #(
		.SAMPLE_BITS(SAMPLE_W),
		.COUNT_BITS (CNT_W),
		.FRAC_BITS  (FRAC_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.mode         (mode),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sample_count (sample_count),
		.mean_value   (mean_value),
		.min_value    (min_value),
		.max_value    (max_value),
		.std_dev      (std_dev),
		.sum_saturated(sum_saturated),
		.count_full   (count_full)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int draw_wait();
		return quiet ? 0 : int'($urandom_range(0, 12));
	endfunction

	function automatic logic [31:0] floor_root(input logic [63:0] v);
		logic [31:0] r;
		logic [31:0] t;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (32'd1 << i);
			if ({32'd0, t} * {32'd0, t} <= v)
				r = t;
		end
		return r;
	endfunction

	// welford update of the predicted state, returns the statistics after the item
	function automatic stats_t apply_item(input logic op, input logic signed [SAMPLE_W-1:0] s);
		longint       x;
		longint       d1;
		longint       d2;
		longint       n_l;
		logic [63:0]  m1;
		logic [63:0]  m2;
		logic [63:0]  term;
		logic [127:0] prod;
		stats_t       r;
		if (op == OP_CLEAR) begin
			n_acc = '0;
			mean_acc = 0;
			min_acc = '0;
			max_acc = '0;
			sq_acc = '0;
			sat_acc = 1'b0;
		end else if (n_acc != CNT_MAX) begin
			n_acc = n_acc + 1'b1;
			n_l = longint'(n_acc);
			x = longint'(s) <<< FRAC_W;
			d1 = x - mean_acc;
			mean_acc = mean_acc + d1 / n_l;
			d2 = x - mean_acc;
			m1 = (d1 < 0) ? -d1 : d1;
			m2 = (d2 < 0) ? -d2 : d2;
			prod = {64'd0, m1} * {64'd0, m2};
			term = prod[FRAC_W +: 64];
			if (|prod[127:64+FRAC_W] || term > ~sq_acc) begin
				sq_acc = '1;
				sat_acc = 1'b1;
			end else begin
				sq_acc = sq_acc + term;
			end
			if (n_acc == 1 || s < min_acc)
				min_acc = s;
			if (n_acc == 1 || s > max_acc)
				max_acc = s;
		end
		r.sat = sat_acc;
		r.full = (n_acc == CNT_MAX);
		if (n_acc == 0) begin
			r.cnt = '0;
			r.mean = '0;
			r.lo = '0;
			r.hi = '0;
			r.sd = '0;
		end else begin
			r.cnt = n_acc;
			r.mean = mean_acc[rmms_pkg::MEAN_W-1:0];
			r.lo = min_acc;
			r.hi = max_acc;
			// frac bits equal the variance scale, so no shift before the root
			r.sd = floor_root(sq_acc / n_acc);
		end
		return r;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t %s: expected %h, got %h", $time, what, want, got);
		end
	endtask

	task automatic check_stats();
		stats_t due;
		if (stats_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t result with no item pending", $time);
			return;
		end
		due = stats_due.pop_front();
		check_field("sample_count", 64'(due.cnt), 64'(sample_count));
		check_field("mean_value", 64'(due.mean), 64'(mean_value));
		check_field("min_value", 64'(due.lo), 64'(min_value));
		check_field("max_value", 64'(due.hi), 64'(max_value));
		check_field("std_dev", 64'(due.sd), 64'(std_dev));
		check_field("sum_saturated", 64'(due.sat), 64'(sum_saturated));
		check_field("count_full", 64'(due.full), 64'(count_full));
	endtask

	// result side: check on accept, then draw the stall for the next result
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid === 1'b1 && !result_stall) begin
				check_stats();
				hold_left = draw_wait();
				result_stall <= (hold_left != 0);
			end else if (result_valid === 1'b1 && result_stall) begin
				hold_left = hold_left - 1;
				if (hold_left <= 0)
					result_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic op, input logic signed [SAMPLE_W-1:0] s);
		int     gap;
		stats_t due;
		gap = draw_wait();
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		mode <= op;
		sample <= s;
		do @(posedge clk); while (sample_stall !== 1'b0);
		due = apply_item(op, s);
		stats_due.push_back(due);
		items_sent++;
	endtask

	task automatic wait_for_results();
		sample_valid <= 1'b0;
		while (stats_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(
		input logic signed [SAMPLE_W-1:0] base, input int spread);
		logic signed [SAMPLE_W-1:0] off;
		case (spread)
			0: return SAMPLE_W'($urandom());
			1: return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
			2: begin
				off = SAMPLE_W'($urandom_range(0, 255));
				return SAMPLE_W'(base + off - 128);
			end
			default: begin
				off = SAMPLE_W'($urandom_range(0, 65535));
				return SAMPLE_W'(base + off - 32768);
			end
		endcase
	endfunction

	// empty state, first sample, extremes, negative mean, sum saturation and clear
	task automatic test_directed();
		send_item(OP_CLEAR, SAMPLE_MIN);
		send_item(OP_ADD, '0);
		send_item(OP_ADD, SAMPLE_W'(-1));
		send_item(OP_ADD, SAMPLE_MAX);
		send_item(OP_ADD, SAMPLE_MIN);
		send_item(OP_CLEAR, SAMPLE_MAX);
		send_item(OP_ADD, SAMPLE_MIN);
		for (int i = 0; i < 4; i++) begin
			send_item(OP_ADD, SAMPLE_MAX);
			send_item(OP_ADD, SAMPLE_MIN);
		end
		send_item(OP_ADD, SAMPLE_W'(5));
		wait_for_results();
		send_item(OP_CLEAR, '0);
		send_item(OP_ADD, SAMPLE_W'(1));
		send_item(OP_ADD, SAMPLE_W'(2));
		send_item(OP_ADD, SAMPLE_W'(-3));
	endtask

	// one long run without a clear, count grows past one byte
	task automatic test_long_run();
		logic signed [SAMPLE_W-1:0] base;
		base = SAMPLE_W'($urandom());
		send_item(OP_CLEAR, '0);
		for (int i = 0; i < LONG_RUN; i++)
			send_item(OP_ADD, pick_sample(base, 3));
		send_item(OP_ADD, SAMPLE_MAX);
		send_item(OP_ADD, SAMPLE_MIN);
		send_item(OP_ADD, '0);
		send_item(OP_CLEAR, SAMPLE_MAX);
	endtask

	task automatic test_random_runs();
		int                         run_len;
		int                         spread;
		bit                         drained;
		logic signed [SAMPLE_W-1:0] base;
		drained = 1'b0;
		while (items_sent < ITEMS) begin
			quiet = ($urandom_range(0, 4) == 0);
			send_item(OP_CLEAR, SAMPLE_W'($urandom()));
			run_len = ($urandom_range(0, 11) == 0) ? $urandom_range(250, 270)
				: $urandom_range(1, 40);
			base = SAMPLE_W'($urandom());
			spread = $urandom_range(0, 3);
			for (int i = 0; i < run_len; i++) begin
				if ($urandom_range(0, 49) == 0)
					send_item(OP_CLEAR, SAMPLE_W'($urandom()));
				else
					send_item(OP_ADD, pick_sample(base, spread));
			end
			if (!drained && items_sent > ITEMS / 2) begin
				wait_for_results();
				drained = 1'b1;
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_run();
		test_random_runs();
		wait_for_results();
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
design/rmms_pkg.sv
design/rmms_div.sv
design/rmms_mul.sv
design/rmms_sqrt.sv
design/running_mean_min_max_stddev.sv
design/rmms_checker.sv
tb/tb_top.sv
